@@ rtl/sts_pkg.sv @@
// Shared constants for the timer scheduler: command and result kind codes.
// Used by the slot cell and the top level; no dependencies.
package sts_pkg;
   localparam int SlotsDefault = 8;
   localparam int MaxFire = 8;
   localparam logic [2:0] CMD_REGISTER = 3'd0;
   localparam logic [2:0] CMD_UNREGISTER = 3'd1;
   localparam logic [2:0] CMD_RESET = 3'd2;
   localparam logic [2:0] CMD_TICK = 3'd3;
   localparam logic [2:0] CMD_READ_TIME = 3'd4;
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_TIME = 2'd2;

   // Candidate handed along the cell chain during a tick search.
   typedef struct packed {
      logic        found;
      logic [63:0] expiry;
   } cand_type;
endpackage

@@ rtl/software_timer_scheduler_core.sv @@
// Top level of the timer scheduler: time extension, command sequencer,
// slot cell chain and result register. Depends on sts_pkg and sts_cell.
//
// The input is stalled while a transaction is in flight, so items are handled
// one at a time. A command other than a tick executes once the output register
// is free and loads its result then, so the next item can be accepted after
// that. A tick searches the slot chain for the earliest due expiry; the
// candidate moves one cell per cycle, so a search passes all SLOTS cells
// before the found slot fires. With eight firings the closing search is
// skipped. Every result also waits for the output register to be free, so a
// stalling receiver delays it. Results leave through a single output
// register, so the next transaction can be accepted while the last result of
// the previous one still waits.
module software_timer_scheduler_core #(
   parameter int SLOTS = sts_pkg::SlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_slot,
   input  logic [31:0] req_duration_us,
   input  logic        req_one_shot,
   input  logic [31:0] req_clock_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_fired_slot,
   output logic        rsp_status,
   output logic [63:0] rsp_time_us,
   output logic        rsp_last
);
   import sts_pkg::*;
   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntW = $clog2(MaxFire + 1);
   localparam int SrchW = $clog2(SLOTS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_TICK = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [63:0] time_ff, time_in;
   logic [31:0] prev_ff, prev_in;
   logic [2:0] cmd_ff, cmd_in, slot_ff, slot_in;
   logic [31:0] dur_ff, dur_in;
   logic os_ff, os_in;
   logic [CntW-1:0] nfire_ff, nfire_in;
   logic [SrchW-1:0] srch_ff, srch_in;
   logic pend_ff, pend_in;
   logic [IdxW-1:0] pslot_ff, pslot_in;
   logic ov_ff, ov_in;
   logic [1:0] okind_ff, okind_in;
   logic [2:0] oslot_ff, oslot_in;
   logic ostat_ff, ostat_in, olast_ff, olast_in;
   logic [63:0] otime_ff, otime_in;

   logic accept, out_free, cmd_en, fire_en, tick_start;
   logic slot_ok, srch_done, fire_full;
   cand_type chain_c [SLOTS+1];
   logic [IdxW-1:0] chain_i [SLOTS+1];
   logic [SLOTS-1:0] act_vec;
   logic [IdxW-1:0] sel_idx;

   assign out_free = !ov_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign slot_ok = ({29'd0, slot_ff} < 32'(SLOTS));
   assign sel_idx = IdxW'(slot_ff);
   assign chain_c[0] = '0;
   assign chain_i[0] = '0;
   assign cmd_en = (state_ff == ST_EXEC) && out_free && slot_ok;
   assign tick_start = accept;
   // The chain output reflects the current slot state once the candidate has
   // passed all SLOTS cells since the last change.
   assign srch_done = (srch_ff == SrchW'(SLOTS));
   assign fire_full = (nfire_ff == CntW'(MaxFire));
   assign fire_en = (state_ff == ST_TICK) && out_free && srch_done && !fire_full
                    && chain_c[SLOTS].found;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      sts_cell #(.IdxW(IdxW)) u_cell (
         .clock(clock), .reset(reset), .my_index(IdxW'(g)),
         .cmd_en(cmd_en), .cmd(cmd_ff), .sel(sel_idx == IdxW'(g)),
         .duration_us(dur_ff), .one_shot(os_ff), .now(time_ff),
         .cand_left(chain_c[g]), .idx_left(chain_i[g]),
         .cand_right(chain_c[g+1]), .idx_right(chain_i[g+1]),
         .fire_en(fire_en), .fire_idx(chain_i[SLOTS]),
         .tick_start(tick_start), .active(act_vec[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      time_in = time_ff;
      prev_in = prev_ff;
      cmd_in = cmd_ff; slot_in = slot_ff; dur_in = dur_ff; os_in = os_ff;
      nfire_in = nfire_ff;
      pend_in = pend_ff; pslot_in = pslot_ff;
      srch_in = srch_done ? srch_ff : srch_ff + 1'b1;
      ov_in = ov_ff && rsp_stall;
      okind_in = okind_ff; oslot_in = oslot_ff;
      ostat_in = ostat_ff; olast_in = olast_ff; otime_in = otime_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            time_in = time_ff + {32'd0, req_clock_us - prev_ff};
            prev_in = req_clock_us;
            cmd_in = req_command; slot_in = req_slot;
            dur_in = req_duration_us; os_in = req_one_shot;
            nfire_in = '0;
            pend_in = 1'b0;
            srch_in = '0;
            state_in = (req_command == CMD_TICK) ? ST_TICK : ST_EXEC;
         end
         ST_EXEC: if (out_free) begin
            ov_in = 1'b1; olast_in = 1'b1; oslot_in = '0; otime_in = time_ff;
            okind_in = KIND_STATUS; ostat_in = 1'b0;
            case (cmd_ff)
               CMD_REGISTER, CMD_UNREGISTER: ostat_in = !slot_ok;
               CMD_RESET: ostat_in = !slot_ok || !act_vec[sel_idx];
               CMD_READ_TIME: okind_in = KIND_TIME;
               default: ostat_in = 1'b1;
            endcase
            state_in = ST_IDLE;
         end
         ST_TICK: if (out_free && (fire_full || srch_done)) begin
            if (fire_en) begin
               // A new firing shows that the held one was not the last.
               if (pend_ff) begin
                  ov_in = 1'b1;
                  okind_in = KIND_FIRED;
                  oslot_in = 3'(pslot_ff);
                  ostat_in = 1'b0;
                  otime_in = time_ff;
                  olast_in = 1'b0;
               end
               pend_in = 1'b1;
               pslot_in = chain_i[SLOTS];
               nfire_in = nfire_ff + 1'b1;
               srch_in = '0;
            end else begin
               ov_in = 1'b1;
               ostat_in = 1'b0;
               otime_in = time_ff;
               olast_in = 1'b1;
               if (pend_ff) begin
                  okind_in = KIND_FIRED;
                  oslot_in = 3'(pslot_ff);
               end else begin
                  okind_in = KIND_STATUS;
                  oslot_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         time_ff <= '0;
         prev_ff <= '0;
         ov_ff <= 1'b0;
         nfire_ff <= '0;
         srch_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff <= time_in;
         prev_ff <= prev_in;
         ov_ff <= ov_in;
         nfire_ff <= nfire_in;
         srch_ff <= srch_in;
         pend_ff <= pend_in;
      end
      cmd_ff <= cmd_in; slot_ff <= slot_in; dur_ff <= dur_in; os_ff <= os_in;
      pslot_ff <= pslot_in;
      okind_ff <= okind_in; oslot_ff <= oslot_in;
      ostat_ff <= ostat_in; olast_ff <= olast_in; otime_ff <= otime_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = okind_ff;
   assign rsp_fired_slot = oslot_ff;
   assign rsp_status = ostat_ff;
   assign rsp_time_us = otime_ff;
   assign rsp_last = olast_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("busy but not stalling");
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      nfire_ff <= CntW'(MaxFire)) else $error("too many firings");
   a_search_cap: assert property (@(posedge clock) disable iff (reset)
      srch_ff <= SrchW'(SLOTS)) else $error("search counter overrun");
   a_full_pending: assert property (@(posedge clock) disable iff (reset)
      fire_full |-> pend_ff) else $error("full tick without held firing");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> (ov_ff && $stable({okind_ff, oslot_ff, ostat_ff,
      otime_ff, olast_ff}))) else $error("result lost");
endmodule

@@ rtl/sts_cell.sv @@
// One timer slot: holds its state, applies commands and joins the
// earliest-expiry search, passing the better candidate to its right through a register.
// Depends on sts_pkg.
module sts_cell #(
   parameter int IdxW = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IdxW-1:0]     my_index,
   input  logic                cmd_en,
   input  logic [2:0]          cmd,
   input  logic                sel,
   input  logic [31:0]         duration_us,
   input  logic                one_shot,
   input  logic [63:0]         now,
   input  sts_pkg::cand_type   cand_left,
   input  logic [IdxW-1:0]     idx_left,
   output sts_pkg::cand_type   cand_right,
   output logic [IdxW-1:0]     idx_right,
   input  logic                fire_en,
   input  logic [IdxW-1:0]     fire_idx,
   input  logic                tick_start,
   output logic                active
);
   import sts_pkg::*;
   logic active_ff, active_in, os_ff, os_in, done_ff, done_in;
   logic [31:0] period_ff, period_in;
   logic [63:0] expiry_ff, expiry_in;
   cand_type cand_ff, cand_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic due;

   assign active = active_ff;
   assign cand_right = cand_ff;
   assign idx_right = idx_ff;
   assign due = active_ff && !done_ff && (expiry_ff <= now);

   // Strict less-than keeps the lower slot on ties.
   always_comb begin
      cand_in = cand_left;
      idx_in = idx_left;
      if (due && (!cand_left.found || expiry_ff < cand_left.expiry)) begin
         cand_in.found = 1'b1;
         cand_in.expiry = expiry_ff;
         idx_in = my_index;
      end
   end

   always_comb begin
      active_in = active_ff;
      os_in = os_ff;
      period_in = period_ff;
      expiry_in = expiry_ff;
      done_in = done_ff;
      if (tick_start) done_in = 1'b0;
      if (cmd_en && sel) begin
         case (cmd)
            CMD_REGISTER: begin
               active_in = 1'b1;
               os_in = one_shot;
               period_in = duration_us;
               expiry_in = now + {32'd0, duration_us};
            end
            CMD_UNREGISTER: active_in = 1'b0;
            CMD_RESET: if (active_ff) expiry_in = now + {32'd0, period_ff};
            default: ;
         endcase
      end
      if (fire_en && fire_idx == my_index) begin
         done_in = 1'b1;
         if (os_ff) active_in = 1'b0;
         else expiry_in = now + {32'd0, period_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         os_ff <= 1'b0;
         done_ff <= 1'b0;
         cand_ff <= '0;
         idx_ff <= '0;
      end else begin
         active_ff <= active_in;
         os_ff <= os_in;
         done_ff <= done_in;
         cand_ff <= cand_in;
         idx_ff <= idx_in;
      end
      period_ff <= period_in;
      expiry_ff <= expiry_in;
   end
endmodule

@@ tb/sv/tb_software_timer_scheduler_core.sv @@
// Self-checking testbench for the timer scheduler core: drives commands and
// compares every result with a predictor of the slot table. Depends on sts_pkg.
module tb_software_timer_scheduler_core;
   import sts_pkg::*;

   localparam int NumSlots = 8;
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  fired_slot;
      logic        status;
      logic [63:0] time_us;
      logic        last;
   } timer_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic [2:0]  req_slot;
   logic [31:0] req_duration_us;
   logic        req_one_shot;
   logic [31:0] req_clock_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_fired_slot;
   logic        rsp_status;
   logic [63:0] rsp_time_us;
   logic        rsp_last;

   // Predicted slot table and time extension state.
   logic        pred_active [NumSlots];
   logic        pred_one_shot [NumSlots];
   logic [31:0] pred_period [NumSlots];
   logic [63:0] pred_expiry [NumSlots];
   logic [63:0] pred_time;
   logic [31:0] pred_prev_clock;
   logic [31:0] wall_clock;

   timer_result_type expected_results [$];
   int  error_count;
   int  idle_cycles;
   int  send_idle_pct;
   int  recv_stall_pct;

   software_timer_scheduler_core i_dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic timer_result_type make_result(logic [1:0] kind, logic [2:0] fslot,
                                                    logic status, logic last);
      timer_result_type r;
      r.kind = kind;
      r.fired_slot = fslot;
      r.status = status;
      r.time_us = pred_time;
      r.last = last;
      return r;
   endfunction

   function automatic void queue_result(timer_result_type r);
      expected_results = {expected_results, r};
   endfunction

   // Advances the predicted time and queues the results of one transaction.
   task automatic predict_schedule(logic [2:0] cmd, logic [2:0] slot,
                                   logic [31:0] dur, logic os, logic [31:0] clk);
      logic done [NumSlots];
      logic [31:0] delta;
      int fired;
      int best;
      delta = clk - pred_prev_clock;
      pred_time = pred_time + {32'd0, delta};
      pred_prev_clock = clk;
      case (cmd)
         CMD_REGISTER: begin
            pred_active[slot] = 1'b1;
            pred_one_shot[slot] = os;
            pred_period[slot] = dur;
            pred_expiry[slot] = pred_time + 64'(dur);
            queue_result(make_result(KIND_STATUS, 3'd0, 1'b0, 1'b1));
         end
         CMD_UNREGISTER: begin
            pred_active[slot] = 1'b0;
            queue_result(make_result(KIND_STATUS, 3'd0, 1'b0, 1'b1));
         end
         CMD_RESET: begin
            if (pred_active[slot]) begin
               pred_expiry[slot] = pred_time + 64'(pred_period[slot]);
               queue_result(make_result(KIND_STATUS, 3'd0, 1'b0, 1'b1));
            end else begin
               queue_result(make_result(KIND_STATUS, 3'd0, 1'b1, 1'b1));
            end
         end
         CMD_TICK: begin
            fired = 0;
            foreach (done[i]) done[i] = 1'b0;
            while (fired < MaxFire) begin
               best = -1;
               for (int i = 0; i < NumSlots; i++) begin
                  if (pred_active[i] && !done[i] && pred_expiry[i] <= pred_time &&
                      (best < 0 || pred_expiry[i] < pred_expiry[best]))
                     best = i;
               end
               if (best < 0) break;
               done[best] = 1'b1;
               if (pred_one_shot[best]) pred_active[best] = 1'b0;
               else pred_expiry[best] = pred_time + 64'(pred_period[best]);
               queue_result(make_result(KIND_FIRED, 3'(best), 1'b0, 1'b0));
               fired++;
            end
            if (fired == 0)
               queue_result(make_result(KIND_STATUS, 3'd0, 1'b0, 1'b1));
            else
               expected_results[$].last = 1'b1;
         end
         CMD_READ_TIME:
            queue_result(make_result(KIND_TIME, 3'd0, 1'b0, 1'b1));
         default:
            queue_result(make_result(KIND_STATUS, 3'd0, 1'b1, 1'b1));
      endcase
   endtask

   // Sends one transaction after an optional random gap. Valid stays high after
   // acceptance until the next transaction or gap replaces it in the same step.
   task automatic send_command(logic [2:0] cmd, logic [2:0] slot, logic [31:0] dur,
                               logic os, logic [31:0] clk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_slot <= slot;
      req_duration_us <= dur;
      req_one_shot <= os;
      req_clock_us <= clk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_schedule(cmd, slot, dur, os, clk);
   endtask

   // Moves the wall clock forward and sends a command at the new sample.
   task automatic step_command(logic [2:0] cmd, logic [2:0] slot, logic [31:0] dur,
                               logic os, int unsigned advance);
      wall_clock = wall_clock + advance;
      send_command(cmd, slot, dur, os, wall_clock);
   endtask

   task automatic test_directed_commands();
      step_command(CMD_READ_TIME, 3'd0, 32'd0, 1'b0, 0);
      step_command(CMD_RESET, 3'd3, 32'd0, 1'b0, 5);
      step_command(CMD_UNREGISTER, 3'd7, 32'd0, 1'b0, 1);
      step_command(CMD_REGISTER, 3'd0, 32'd0, 1'b0, 2);
      step_command(CMD_REGISTER, 3'd7, 32'hFFFF_FFFF, 1'b1, 0);
      step_command(CMD_REGISTER, 3'd2, 32'd10, 1'b1, 0);
      step_command(CMD_REGISTER, 3'd5, 32'd10, 1'b0, 0);
      step_command(CMD_TICK, 3'd0, 32'd0, 1'b0, 20);
      step_command(CMD_TICK, 3'd0, 32'd0, 1'b0, 0);
      step_command(CMD_RESET, 3'd5, 32'd0, 1'b0, 3);
      step_command(CMD_REGISTER, 3'd5, 32'd4, 1'b1, 0);
      step_command(3'd5, 3'd0, 32'd0, 1'b0, 0);
      step_command(3'd6, 3'd1, 32'd0, 1'b0, 0);
      step_command(3'd7, 3'd2, 32'd0, 1'b0, 0);
      // The wall clock wraps past its 32-bit limit here.
      wall_clock = 32'hFFFF_FFF0;
      step_command(CMD_READ_TIME, 3'd0, 32'd0, 1'b0, 0);
      step_command(CMD_TICK, 3'd0, 32'd0, 1'b0, 32'h20);
      step_command(CMD_READ_TIME, 3'd0, 32'd0, 1'b0, 0);
      step_command(CMD_UNREGISTER, 3'd7, 32'd0, 1'b0, 0);
      step_command(CMD_UNREGISTER, 3'd0, 32'd0, 1'b0, 0);
      step_command(CMD_TICK, 3'd0, 32'd0, 1'b0, 0);
   endtask

   // Arms every slot with the same expiry so that one tick fires all eight.
   task automatic test_full_tick();
      for (int i = 0; i < NumSlots; i++)
         step_command(CMD_REGISTER, 3'(i), 32'd50, 1'(i % 2), 0);
      step_command(CMD_TICK, 3'd0, 32'd0, 1'b0, 50);
      step_command(CMD_TICK, 3'd0, 32'd0, 1'b0, 60);
   endtask

   task automatic test_random_schedule(int count);
      logic [2:0] cmd;
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30) cmd = CMD_REGISTER;
         else if (pick < 40) cmd = CMD_UNREGISTER;
         else if (pick < 50) cmd = CMD_RESET;
         else if (pick < 85) cmd = CMD_TICK;
         else if (pick < 95) cmd = CMD_READ_TIME;
         else cmd = 3'($urandom_range(7, 5));
         if ($urandom_range(19) == 0)
            send_command(cmd, 3'($urandom_range(7)), $urandom, 1'($urandom),
                         $urandom);
         else
            step_command(cmd, 3'($urandom_range(7)),
                         ($urandom_range(9) == 0) ? $urandom : $urandom_range(40),
                         1'($urandom), $urandom_range(25));
         if (cmd == CMD_REGISTER && $urandom_range(9) == 0)
            wall_clock = $urandom;
      end
   endtask

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d slot %0d time %0d", $time,
                     rsp_kind, rsp_fired_slot, rsp_time_us);
            error_count++;
         end else begin
            timer_result_type want;
            want = expected_results.pop_front();
            if (want.kind !== rsp_kind || want.fired_slot !== rsp_fired_slot ||
                want.status !== rsp_status || want.time_us !== rsp_time_us ||
                want.last !== rsp_last) begin
               $display("%0t: mismatch expected kind %0d slot %0d status %0d time %0d last %0d",
                        $time, want.kind, want.fired_slot, want.status, want.time_us,
                        want.last);
               $display("%0t:          actual kind %0d slot %0d status %0d time %0d last %0d",
                        $time, rsp_kind, rsp_fired_slot, rsp_status, rsp_time_us,
                        rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int wait_cycles;
      error_count = 0;
      idle_cycles = 0;
      send_idle_pct = 16;
      recv_stall_pct = 59;
      wall_clock = 0;
      pred_time = 0;
      pred_prev_clock = 0;
      for (int i = 0; i < NumSlots; i++) begin
         pred_active[i] = 1'b0;
         pred_one_shot[i] = 1'b0;
         pred_period[i] = 0;
         pred_expiry[i] = 0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_READ_TIME;
      req_slot = 0;
      req_duration_us = 0;
      req_one_shot = 0;
      req_clock_us = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_commands();
      test_full_tick();
      test_random_schedule(100);
      send_idle_pct = 59;
      recv_stall_pct = 16;
      test_random_schedule(100);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_schedule(100);
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < WatchdogLimit) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (30) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
